/* rtl/hsv2rgb_pkg.sv */
// Package for the HSV to RGB converter: item types, sector codes, fixed-point
// constants and the Q0.16 product reduction shared by the pipeline stages.
// Depends on nothing.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

  localparam logic [14:0] HueFull   = 15'd23040;  // 360 degrees in 1/64 degree
  localparam logic [14:0] HueSector = 15'd3840;   // 60 degrees in 1/64 degree
  localparam logic [15:0] OneQ16    = 16'hFFFF;   // Q0.16 one
  // 65535 / 3840 reduces to 4369 / 256, so the fraction is a multiply and a shift.
  localparam logic [12:0] FracMul   = 13'd4369;

  typedef enum logic [1:0] {
    KindBlack,
    KindGray,
    KindColour
  } kind_e;

  typedef enum logic [2:0] {
    SecRedYellow,
    SecYellowGreen,
    SecGreenCyan,
    SecCyanBlue,
    SecBlueMagenta,
    SecMagentaRed
  } sector_e;

  typedef struct packed {
    kind_e       kind;
    sector_e     sector;
    logic [15:0] frac;
    logic [15:0] sat;
    logic [15:0] val;
  } hsv2rgb_item_t;

  // floor(x / 65535) for x <= 65535 * 65535. With x = 65536*hi + lo the
  // remainder against hi is lo + hi, which stays below twice 65535.
  function automatic logic [15:0] qred(input logic [31:0] x);
    logic [16:0] rem;
    rem = {1'b0, x[15:0]} + {1'b0, x[31:16]};
    if (rem >= {1'b0, OneQ16}) begin
      qred = x[31:16] + 16'd1;
    end else begin
      qred = x[31:16];
    end
  endfunction

endpackage

/* rtl/hsv2rgb_front.sv */
// Front end of the HSV to RGB converter: accepts an item, folds the hue,
// finds the sector and fraction and classifies black, gray or colour.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [14:0]   hue_i,
  input  logic [15:0]   saturation_i,
  input  logic [15:0]   brightness_i,
  output logic          item_valid_o,
  input  logic          item_ready_i,
  output hsv2rgb_item_t item_o
);

  logic          valid_q, valid_d;
  hsv2rgb_item_t item_q, item_d;
  logic          accept;
  logic [14:0]   hue;
  logic [14:0]   base;
  logic [11:0]   rem;
  logic [24:0]   frac_prod;

  assign in_stall_o = valid_q && !item_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    hue = (hue_i >= HueFull) ? 15'd0 : hue_i;
    item_d.sector = SecRedYellow;
    base          = 15'd0;
    priority if (hue >= 15'(5 * HueSector)) begin
      item_d.sector = SecMagentaRed;
      base          = 15'(5 * HueSector);
    end else if (hue >= 15'(4 * HueSector)) begin
      item_d.sector = SecBlueMagenta;
      base          = 15'(4 * HueSector);
    end else if (hue >= 15'(3 * HueSector)) begin
      item_d.sector = SecCyanBlue;
      base          = 15'(3 * HueSector);
    end else if (hue >= 15'(2 * HueSector)) begin
      item_d.sector = SecGreenCyan;
      base          = 15'(2 * HueSector);
    end else if (hue >= HueSector) begin
      item_d.sector = SecYellowGreen;
      base          = HueSector;
    end
    rem         = 12'(hue - base);
    frac_prod   = {13'd0, rem} * {12'd0, FracMul};
    item_d.frac = frac_prod[23:8];
    item_d.sat  = saturation_i;
    item_d.val  = brightness_i;
    priority if (brightness_i == 16'd0) begin
      item_d.kind = KindBlack;
    end else if (saturation_i == 16'd0) begin
      item_d.kind = KindGray;
    end else begin
      item_d.kind = KindColour;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (item_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

/* rtl/hsv2rgb_queue.sv */
// Short queue of classified items between the front end and the back end.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_queue import hsv2rgb_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  hsv2rgb_item_t push_item_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output hsv2rgb_item_t pop_item_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  hsv2rgb_item_t       slots_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_item_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

/* rtl/hsv2rgb_back.sv */
// Back end of the HSV to RGB converter: four-stage multiply pipeline forming
// p, q and t and routing them by sector into the output register.
// Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_back import hsv2rgb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          item_valid_i,
  output logic          item_ready_o,
  input  hsv2rgb_item_t item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [15:0]   red_o,
  output logic [15:0]   green_o,
  output logic [15:0]   blue_o
);

  typedef struct packed {
    kind_e       kind;
    sector_e     sector;
    logic [15:0] val;
  } route_t;

  logic        en;
  logic        s1_v_q, s2_v_q, s3_v_q, out_v_q;
  route_t      s1_r_q, s2_r_q, s3_r_q;
  logic [31:0] s1_pp_q, s1_fs_q, s1_ts_q;
  logic [15:0] s2_p_q, s2_aq_q, s2_at_q;
  logic [15:0] s3_p_q;
  logic [31:0] s3_qq_q, s3_tt_q;
  logic [15:0] q_val, t_val;
  logic [15:0] red_d, green_d, blue_d;
  logic [15:0] red_q, green_q, blue_q;

  // The whole pipeline advances together unless a finished item is held.
  assign en           = !(out_v_q && out_stall_i);
  assign item_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= item_valid_i;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  assign q_val = qred(s3_qq_q);
  assign t_val = qred(s3_tt_q);

  always_comb begin
    red_d   = s3_r_q.val;
    green_d = s3_r_q.val;
    blue_d  = s3_r_q.val;
    unique case (s3_r_q.kind)
      KindBlack: begin
        red_d   = 16'd0;
        green_d = 16'd0;
        blue_d  = 16'd0;
      end
      KindColour: begin
        unique case (s3_r_q.sector)
          SecRedYellow: begin
            red_d = s3_r_q.val; green_d = t_val; blue_d = s3_p_q;
          end
          SecYellowGreen: begin
            red_d = q_val; green_d = s3_r_q.val; blue_d = s3_p_q;
          end
          SecGreenCyan: begin
            red_d = s3_p_q; green_d = s3_r_q.val; blue_d = t_val;
          end
          SecCyanBlue: begin
            red_d = s3_p_q; green_d = q_val; blue_d = s3_r_q.val;
          end
          SecBlueMagenta: begin
            red_d = t_val; green_d = s3_p_q; blue_d = s3_r_q.val;
          end
          default: begin
            red_d = s3_r_q.val; green_d = s3_p_q; blue_d = q_val;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_r_q  <= '{kind: item_i.kind, sector: item_i.sector, val: item_i.val};
      s1_pp_q <= {16'd0, item_i.val} * {16'd0, OneQ16 - item_i.sat};
      s1_fs_q <= {16'd0, item_i.frac} * {16'd0, item_i.sat};
      s1_ts_q <= {16'd0, OneQ16 - item_i.frac} * {16'd0, item_i.sat};

      s2_r_q  <= s1_r_q;
      s2_p_q  <= qred(s1_pp_q);
      s2_aq_q <= OneQ16 - qred(s1_fs_q);
      s2_at_q <= OneQ16 - qred(s1_ts_q);

      s3_r_q  <= s2_r_q;
      s3_p_q  <= s2_p_q;
      s3_qq_q <= {16'd0, s2_r_q.val} * {16'd0, s2_aq_q};
      s3_tt_q <= {16'd0, s2_r_q.val} * {16'd0, s2_at_q};

      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

/* rtl/hsv_to_rgb_converter.sv */
// HSV to RGB converter, one pixel item in and one pixel item out.
// An accepted item passes through the front register, the queue, two multiply
// stages and two reduction stages before its result shows.
// Throughput: one item per cycle unless stalled, as multipliers are fully pipelined.
// Reset: rst_ni clears all valid flags, queue pointers and counts; data
// registers are not reset.
`timescale 1ns / 1ps

module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [14:0] hue_i,
  input  logic [15:0] saturation_i,
  input  logic [15:0] brightness_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] red_o,
  output logic [15:0] green_o,
  output logic [15:0] blue_o
);

  // The front end folds hue at or above 360 degrees to zero, splits it into a
  // sector and a Q0.16 fraction, and tags each item as black (zero value),
  // gray (zero saturation) or colour. Its register stalls only when the queue
  // is full.
  logic          fr_valid, fr_ready;
  hsv2rgb_item_t fr_item;

  // The queue lets the front end keep taking items while the output side is
  // stalled, until the queue itself is full.
  logic          bk_valid, bk_ready;
  hsv2rgb_item_t bk_item;

  hsv2rgb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  hsv2rgb_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_item_o   (bk_item)
  );

  // The back end forms p, q and t with truncating Q0.16 products and routes
  // them by sector. Its stages all move together, and they hold whenever the
  // output register carries an item that the receiver is stalling.
  hsv2rgb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (bk_valid),
    .item_ready_o (bk_ready),
    .item_i       (bk_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for the HSV to RGB pixel converter.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter from the rtl folder.
`timescale 1ns / 1ps

module testbench import hsv2rgb_pkg::*;;

  // An RGB pixel as the block presents it on its result channel.
  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
  } rgb_pixel_t;

  // Clock and reset. Reset is held low from time zero until the run releases it.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // Input channel, driven from the stimulus process only.
  logic        in_valid_i = 1'b0;
  logic [14:0] hue_i = '0;
  logic [15:0] saturation_i = '0;
  logic [15:0] brightness_i = '0;
  logic        in_stall_o;

  // Result channel. The stall is driven by its own process below.
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] red_o;
  logic [15:0] green_o;
  logic [15:0] blue_o;

  hsv_to_rgb_converter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o)
  );

  // Pixels that the block owes us, oldest first.
  rgb_pixel_t pending_rgb[$];
  int unsigned error_count = 0;

  // Percentages of cycles in which the sender leaves a gap and the receiver
  // stalls. The test tasks change them to move between idling phases.
  int unsigned send_gap_pct = 0;
  int unsigned out_stall_pct = 0;

  // A request from a test for one long receiver hold-off. The stall process
  // picks it up and counts the stretch down itself.
  bit          hold_off_req = 1'b0;
  int unsigned hold_off_left = 0;

  // ---------------------------------------------------------------------------
  // Prediction.
  // ---------------------------------------------------------------------------

  // Product of two Q0.16 numbers where 65535 stands for one, truncated, so
  // that one times x is x exactly.
  function automatic logic [15:0] q16_product(input logic [15:0] a, input logic [15:0] b);
    int unsigned wide;
    wide = (32'(a) * 32'(b)) / 32'(OneQ16);
    return wide[15:0];
  endfunction

  // Works out the RGB pixel for one HSV item. The hue is split into a
  // sector of 3840 units and a fraction f in Q0.16; the three channels are
  // then picked from v, p, q and t according to the sector.
  function automatic rgb_pixel_t hsv_pixel_to_rgb(input logic [14:0] hue,
                                                  input logic [15:0] sat,
                                                  input logic [15:0] val);
    rgb_pixel_t  pix;
    int unsigned hue_in_range;
    int unsigned rem;
    logic [15:0] frac;
    logic [15:0] p_chan;
    logic [15:0] q_chan;
    logic [15:0] t_chan;
    sector_e     sector;
    int unsigned frac_wide;

    // A full turn or more wraps to red.
    hue_in_range = (hue >= HueFull) ? 0 : int'(hue);

    if (val == 16'd0) begin
      pix = '0;
    end else if (sat == 16'd0) begin
      pix = '{red: val, green: val, blue: val};
    end else begin
      sector    = sector_e'(hue_in_range / int'(HueSector));
      rem       = hue_in_range % int'(HueSector);
      frac_wide = (rem * int'(OneQ16)) / int'(HueSector);
      frac      = frac_wide[15:0];
      p_chan    = q16_product(val, OneQ16 - sat);
      q_chan    = q16_product(val, OneQ16 - q16_product(frac, sat));
      t_chan    = q16_product(val, OneQ16 - q16_product(OneQ16 - frac, sat));
      case (sector)
        SecRedYellow:   pix = '{red: val,    green: t_chan, blue: p_chan};
        SecYellowGreen: pix = '{red: q_chan, green: val,    blue: p_chan};
        SecGreenCyan:   pix = '{red: p_chan, green: val,    blue: t_chan};
        SecCyanBlue:    pix = '{red: p_chan, green: q_chan, blue: val};
        SecBlueMagenta: pix = '{red: t_chan, green: p_chan, blue: val};
        default:        pix = '{red: val,    green: p_chan, blue: q_chan};
      endcase
    end
    return pix;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus side.
  // ---------------------------------------------------------------------------

  // Offers one HSV item and returns at the clock edge at which it is
  // accepted. The task is always entered at a rising edge, so each call
  // makes at most one assignment to the valid in any time step: a valid
  // that stays high for the next item is simply assigned high again.
  task automatic send_pixel(input logic [14:0] hue, input logic [15:0] sat,
                            input logic [15:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    hue_i        <= hue;
    saturation_i <= sat;
    brightness_i <= val;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    // Accepted at this edge; the result cannot appear before a later edge.
    pending_rgb.push_back(hsv_pixel_to_rgb(hue, sat, val));
  endtask

  // Lowers the valid and waits until every owed pixel has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_rgb.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Saturation and value lean towards their extremes now and then, so that
  // the black and gray paths are reached often enough.
  function automatic logic [15:0] random_q16();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return 16'd0;
    end else if (pick == 1) begin
      return OneQ16;
    end
    return 16'($urandom);
  endfunction

  // Mostly hues within a turn; some at or beyond a full turn, and some raw
  // 15-bit values so that every hue bit is exercised.
  function automatic logic [14:0] random_hue();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) begin
      return 15'($urandom_range(32767, int'(HueFull)));
    end else if (pick == 1) begin
      return 15'($urandom);
    end
    return 15'($urandom_range(int'(HueFull) - 1, 0));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Both ends of every sector, the wrap at a full turn, the largest hue,
  // zero value, zero saturation and the all-zero and all-one pixels.
  task automatic test_directed();
    int unsigned sec;
    send_gap_pct  = 0;
    out_stall_pct = 0;
    for (sec = 0; sec < 6; sec++) begin
      send_pixel(15'(sec * int'(HueSector)), OneQ16, OneQ16);
      send_pixel(15'(sec * int'(HueSector) + int'(HueSector) - 1), 16'h8000, 16'hC000);
    end
    send_pixel(HueFull, OneQ16, OneQ16);
    send_pixel(15'h7FFF, 16'h1234, 16'hABCD);
    send_pixel(15'd1000, 16'hFFFF, 16'd0);
    send_pixel(15'd5000, 16'd0, 16'h7777);
    send_pixel(15'd0, 16'd0, 16'd0);
    send_pixel(15'h7FFF, OneQ16, OneQ16);
    send_pixel(15'd12345, 16'd1, 16'd1);
    send_pixel(HueFull - 15'd1, 16'd1, OneQ16);
    wait_drained();
  endtask

  // Random pixels under one idling setting.
  task automatic test_random_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                                   input int unsigned count);
    int unsigned n;
    send_gap_pct  = gap_pct;
    out_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      send_pixel(random_hue(), random_q16(), random_q16());
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering items, so the pipeline fills and the block stalls its input.
  task automatic test_backpressure();
    int unsigned n;
    send_gap_pct  = 0;
    out_stall_pct = 0;
    hold_off_req  = 1'b1;
    for (n = 0; n < 24; n++) begin
      send_pixel(random_hue(), random_q16(), random_q16());
    end
    wait_drained();
  endtask

  // The sender pauses mid-stream until every owed pixel has arrived, then
  // carries on with the receiver stalling at random.
  task automatic test_drain_pause();
    int unsigned n;
    send_gap_pct  = 0;
    out_stall_pct = 30;
    for (n = 0; n < 8; n++) begin
      send_pixel(random_hue(), random_q16(), random_q16());
    end
    wait_drained();
    for (n = 0; n < 8; n++) begin
      send_pixel(random_hue(), random_q16(), random_q16());
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result side.
  // ---------------------------------------------------------------------------

  // The receiver stalls at random, or solidly through a requested hold-off.
  always @(posedge clk_i) begin
    if (hold_off_req) begin
      hold_off_req  = 1'b0;
      hold_off_left = 80;
    end
    if (hold_off_left != 0) begin
      hold_off_left = hold_off_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch: got %0d, wanted %0d", $realtime, what, got, want);
    error_count++;
  endtask

  // Every accepted result is compared field by field with the oldest owed
  // pixel. Values are those before the edge, as the block drives them with
  // its own registers.
  always @(posedge clk_i) begin
    rgb_pixel_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_rgb.size() == 0) begin
        $display("%0t: pixel arrived with none owed", $realtime);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (red_o !== want.red) begin
          report_mismatch("red", red_o, want.red);
        end
        if (green_o !== want.green) begin
          report_mismatch("green", green_o, want.green);
        end
        if (blue_o !== want.blue) begin
          report_mismatch("blue", blue_o, want.blue);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of the run.
  // ---------------------------------------------------------------------------

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(0, 0, 100);
    test_random_phase(58, 0, 100);
    test_random_phase(0, 58, 100);
    test_random_phase(18, 18, 100);
    test_backpressure();
    test_drain_pause();

    wait_drained();
    out_stall_pct = 0;
    // Let the pipeline run on so that any stray result shows.
    repeat (10) @(posedge clk_i);

    if (pending_rgb.size() != 0) begin
      $display("%0d pixels never arrived", pending_rgb.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // A run that hangs on a handshake ends here.
  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
